### hdl/srb_pkg.sv
package srb_pkg;

    localparam int SEQ_W = 31;
    localparam int LEN_W = 11;
    localparam int TAG_W = 8;

    // depth of the command queue between front and back, and of the result queue
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_EOS     = 2'd2,
        KIND_DISCARD = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_EOS,
        CLS_OVERSIZE,
        CLS_SEGMENT
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_FREE,
        ST_PLACE,
        ST_SCAN_LOW,
        ST_STEP,
        ST_ACK
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic [LEN_W-1:0] payload_length;
        logic [TAG_W-1:0] buffer_tag;
    } seg_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] out_seq_number;
        logic [LEN_W-1:0] out_length;
        logic [TAG_W-1:0] out_tag;
        logic [SEQ_W-1:0] ack_number;
        logic             last;
    } res_item_t;

    typedef struct packed {
        cls_t             cls;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } slot_t;

    // seq + len, saturated at the top of the sequence space
    function automatic logic [SEQ_W-1:0] seq_advance(
        input logic [SEQ_W-1:0] seq,
        input logic [LEN_W-1:0] len
    );
        logic [SEQ_W:0] sum;
        begin
            sum = {1'b0, seq} + (SEQ_W+1)'(len);
            seq_advance = sum[SEQ_W] ? {SEQ_W{1'b1}} : sum[SEQ_W-1:0];
        end
    endfunction

endpackage

### hdl/srb_fifo.sv
module srb_fifo #(
    parameter type entry_t = logic,
    parameter int  DEPTH   = 2
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/srb_front.sv
module srb_front #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int TAG_BITS    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  srb_pkg::seg_item_t  segment,
    output logic                full,
    input  logic                cmd_pop,
    output srb_pkg::cmd_t       cmd,
    output logic                cmd_empty
);

    localparam logic [srb_pkg::TAG_W-1:0] TAG_MASK =
        srb_pkg::TAG_W'((17'(1) << TAG_BITS) - 17'(1));

    srb_pkg::cmd_t cls_cmd;

    // state-free classification: end of stream and oversized length
    always_comb
    begin
        cls_cmd.seq = segment.seq_number;
        cls_cmd.len = segment.payload_length;
        cls_cmd.tag = segment.buffer_tag & TAG_MASK;
        if (segment.payload_length == '0)
        begin
            cls_cmd.cls = srb_pkg::CLS_EOS;
        end
        else if (16'(segment.payload_length) > 16'(MAX_PAYLOAD))
        begin
            cls_cmd.cls = srb_pkg::CLS_OVERSIZE;
        end
        else
        begin
            cls_cmd.cls = srb_pkg::CLS_SEGMENT;
        end
    end

    srb_fifo #(
        .entry_t (srb_pkg::cmd_t),
        .DEPTH   (srb_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

endmodule

### hdl/srb_back.sv
module srb_back #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srb_pkg::cmd_t       cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output srb_pkg::res_item_t  res,
    output logic                res_wr,
    input  logic                res_full
);

    localparam int IDX_W = $clog2(WINDOW_SLOTS);
    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

    srb_pkg::state_t                state_reg, state_next;
    logic [srb_pkg::SEQ_W-1:0]      exp_reg, exp_next;
    logic [WINDOW_SLOTS-1:0]        valid_reg, valid_next;
    srb_pkg::slot_t                 cur_reg, cur_next;
    srb_pkg::slot_t                 best_reg, best_next;
    logic                           found_reg, found_next;
    logic                           dup_reg, dup_next;
    logic [IDX_W-1:0]               sel_idx_reg, sel_idx_next;
    logic [CNT_W-1:0]               scan_cnt_reg, scan_cnt_next;
    logic                           pend_reg, pend_next;
    logic [IDX_W-1:0]               pend_idx_reg, pend_idx_next;

    srb_pkg::slot_t                 slot_mem [WINDOW_SLOTS];
    srb_pkg::slot_t                 rd_data_reg;
    logic                           mem_rd;
    logic                           mem_we;

    logic                           scanning;
    logic                           issue;
    logic                           pend_valid;

    assign scanning   = (state_reg == srb_pkg::ST_SCAN_FREE) ||
                        (state_reg == srb_pkg::ST_SCAN_LOW);
    assign issue      = scanning && (scan_cnt_reg != CNT_W'(WINDOW_SLOTS));
    assign mem_rd     = issue;
    assign pend_valid = valid_reg[pend_idx_reg];

    always_comb
    begin
        state_next    = state_reg;
        exp_next      = exp_reg;
        valid_next    = valid_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        dup_next      = dup_reg;
        sel_idx_next  = sel_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cmd_pop       = 1'b0;
        res_wr        = 1'b0;
        res           = '0;
        mem_we        = 1'b0;

        // slot scan: address goes out one cycle, entry is judged the next
        if (issue)
        begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
            pend_next     = 1'b1;
            pend_idx_next = scan_cnt_reg[IDX_W-1:0];
        end

        case (state_reg)
            srb_pkg::ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = '{seq: cmd.seq, len: cmd.len, tag: cmd.tag};
                    case (cmd.cls)
                        srb_pkg::CLS_EOS:
                        begin
                            res_wr         = 1'b1;
                            res.kind       = srb_pkg::KIND_EOS;
                            res.ack_number = exp_reg;
                            res.last       = 1'b1;
                        end
                        srb_pkg::CLS_OVERSIZE:
                        begin
                            res_wr             = 1'b1;
                            res.kind           = srb_pkg::KIND_DISCARD;
                            res.out_seq_number = cmd.seq;
                            res.out_length     = cmd.len;
                            res.out_tag        = cmd.tag;
                            res.last           = 1'b1;
                        end
                        default:
                        begin
                            scan_cnt_next = '0;
                            found_next    = 1'b0;
                            dup_next      = 1'b0;
                            if (cmd.seq == exp_reg)
                            begin
                                res_wr             = 1'b1;
                                res.kind           = srb_pkg::KIND_DELIVER;
                                res.out_seq_number = cmd.seq;
                                res.out_length     = cmd.len;
                                res.out_tag        = cmd.tag;
                                exp_next           = srb_pkg::seq_advance(cmd.seq, cmd.len);
                                state_next         = srb_pkg::ST_SCAN_LOW;
                            end
                            else if (cmd.seq < exp_reg)
                            begin
                                res_wr             = 1'b1;
                                res.kind           = srb_pkg::KIND_DISCARD;
                                res.out_seq_number = cmd.seq;
                                res.out_length     = cmd.len;
                                res.out_tag        = cmd.tag;
                                state_next         = srb_pkg::ST_ACK;
                            end
                            else
                            begin
                                state_next = srb_pkg::ST_SCAN_FREE;
                            end
                        end
                    endcase
                end
            end

            srb_pkg::ST_SCAN_FREE:
            begin
                if (pend_reg)
                begin
                    if (pend_valid && (rd_data_reg.seq == cur_reg.seq))
                    begin
                        dup_next = 1'b1;
                    end
                    if (!pend_valid && !found_reg)
                    begin
                        found_next   = 1'b1;
                        sel_idx_next = pend_idx_reg;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = srb_pkg::ST_PLACE;
                end
            end

            srb_pkg::ST_PLACE:
            begin
                if (dup_reg || !found_reg)
                begin
                    if (!res_full)
                    begin
                        res_wr             = 1'b1;
                        res.kind           = srb_pkg::KIND_DISCARD;
                        res.out_seq_number = cur_reg.seq;
                        res.out_length     = cur_reg.len;
                        res.out_tag        = cur_reg.tag;
                        res.last           = 1'b1;
                        state_next         = srb_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    mem_we                  = 1'b1;
                    valid_next[sel_idx_reg] = 1'b1;
                    state_next              = srb_pkg::ST_IDLE;
                end
            end

            srb_pkg::ST_SCAN_LOW:
            begin
                if (pend_reg && pend_valid &&
                    (!found_reg || (rd_data_reg.seq < best_reg.seq)))
                begin
                    found_next   = 1'b1;
                    sel_idx_next = pend_idx_reg;
                    best_next    = rd_data_reg;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = srb_pkg::ST_STEP;
                end
            end

            srb_pkg::ST_STEP:
            begin
                if (!found_reg || (best_reg.seq > exp_reg))
                begin
                    // nothing continues the stream: close with the ack
                    if (!res_full)
                    begin
                        res_wr         = 1'b1;
                        res.kind       = srb_pkg::KIND_ACK;
                        res.ack_number = exp_reg;
                        res.last       = 1'b1;
                        state_next     = srb_pkg::ST_IDLE;
                    end
                end
                else if (!res_full)
                begin
                    res_wr             = 1'b1;
                    res.out_seq_number = best_reg.seq;
                    res.out_length     = best_reg.len;
                    res.out_tag        = best_reg.tag;
                    if (best_reg.seq < exp_reg)
                    begin
                        res.kind = srb_pkg::KIND_DISCARD;
                    end
                    else
                    begin
                        res.kind = srb_pkg::KIND_DELIVER;
                        exp_next = srb_pkg::seq_advance(best_reg.seq, best_reg.len);
                    end
                    valid_next[sel_idx_reg] = 1'b0;
                    scan_cnt_next           = '0;
                    found_next              = 1'b0;
                    state_next              = srb_pkg::ST_SCAN_LOW;
                end
            end

            srb_pkg::ST_ACK:
            begin
                if (!res_full)
                begin
                    res_wr         = 1'b1;
                    res.kind       = srb_pkg::KIND_ACK;
                    res.ack_number = exp_reg;
                    res.last       = 1'b1;
                    state_next     = srb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srb_pkg::ST_IDLE;
            exp_reg      <= '0;
            valid_reg    <= '0;
            found_reg    <= 1'b0;
            dup_reg      <= 1'b0;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            exp_reg      <= exp_next;
            valid_reg    <= valid_next;
            found_reg    <= found_next;
            dup_reg      <= dup_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        sel_idx_reg  <= sel_idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    // descriptor store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[sel_idx_reg] <= cur_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= slot_mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

endmodule

### hdl/segment_reorder_buffer.sv
// segment_reorder_buffer: receive-side reorder logic for byte-numbered segments.
// A segment beat (seq_number, payload_length, buffer_tag) goes in through a queue
// interface (push/full) and result beats come out through another (empty/pop).
// A segment at the expected number is delivered, followed by every buffered
// segment that now continues the stream (stale overlapping ones are reported as
// discards), and then an ack with the new expected number. A late segment gives
// a discard and an ack; an early one is buffered in one of WINDOW_SLOTS slots and
// gives no result, unless it duplicates a buffered seq or the table is full, in
// which case it is discarded. Length zero gives one end-of-stream beat carrying
// the expected number; a length above MAX_PAYLOAD is discarded. The last beat
// caused by each segment has last set. Timing: the front takes a segment every
// cycle until its two-entry command queue fills. The back handles one segment at
// a time: end of stream, oversize and late segments need no slot scan; an early
// segment takes a full pass over the slot store for its scan, then its placement;
// an in-order segment takes one pass for the delivery and one per buffered segment
// flushed, each flush step being a full pass over the slot store, which has a
// single registered read port. A four-entry result queue lets the consumer stall
// without stopping the back until it fills.
module segment_reorder_buffer #(
    parameter int WINDOW_SLOTS = 8,
    parameter int MAX_PAYLOAD  = 1024,
    parameter int TAG_BITS     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // segment side
    input  logic                push,
    input  srb_pkg::seg_item_t  segment,
    output logic                full,
    // result side
    input  logic                pop,
    output srb_pkg::res_item_t  result,
    output logic                empty
);

    // front to back command queue
    srb_pkg::cmd_t      cmd;
    logic               cmd_empty;
    logic               cmd_pop;

    // back to result queue
    srb_pkg::res_item_t res;
    logic               res_wr;
    logic               res_full;

    // classifies each segment beat and queues it
    srb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .TAG_BITS    (TAG_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .segment   (segment),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    // keeps the expected number and the slot table, emits result beats
    srb_back #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_wr    (res_wr),
        .res_full  (res_full)
    );

    // result beats wait here for the consumer
    srb_fifo #(
        .entry_t (srb_pkg::res_item_t),
        .DEPTH   (srb_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

### verif/tb_segment_reorder_buffer.sv
`timescale 1ns / 1ps

module tb_segment_reorder_buffer;

    // block configuration, kept at the defaults of the design
    localparam int WINDOW_SLOTS = 8;
    localparam int MAX_PAYLOAD  = 1024;
    localparam int TAG_BITS     = 8;

    localparam logic [srb_pkg::SEQ_W-1:0] MAX_SEQ = {srb_pkg::SEQ_W{1'b1}};

    // worst in-order segment: eight flush steps over the slot store, plus the ack
    localparam int FLUSH_CYCLES = (WINDOW_SLOTS + 1) * (WINDOW_SLOTS + 3) + 1;
    localparam int SETTLE_CYCLES = 2 * FLUSH_CYCLES + 20;
    localparam int CYCLE_LIMIT = 400_000;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // segment side
    logic               push    = 1'b0;
    srb_pkg::seg_item_t segment = '0;
    logic               full;

    // result side
    logic               pop     = 1'b0;
    srb_pkg::res_item_t result;
    logic               empty;

    segment_reorder_buffer #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .TAG_BITS     (TAG_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .segment (segment),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty)
    );

    // idling on both sides; cleared for the last part of the run
    bit idle_enable = 1'b1;

    // result beats still owed by the block, oldest first
    srb_pkg::res_item_t due_beats[$];

    // predictor state: next in-order byte and the table of early segments
    logic [srb_pkg::SEQ_W-1:0] next_seq = '0;
    bit                        held_valid [WINDOW_SLOTS];
    srb_pkg::slot_t            held_slot  [WINDOW_SLOTS];

    // run statistics
    int mismatches     = 0;
    int segments_sent  = 0;
    int beats_checked  = 0;
    int deliver_beats  = 0;
    int ack_beats      = 0;
    int discard_beats  = 0;
    int eos_beats      = 0;
    int table_overflow = 0;
    int stale_drops    = 0;
    int deepest_flush  = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // start + length, clipped at the top of the sequence space
    function automatic logic [srb_pkg::SEQ_W-1:0] seq_after(
        input logic [srb_pkg::SEQ_W-1:0] start,
        input logic [srb_pkg::LEN_W-1:0] length
    );
        longint unsigned total;
        begin
            total = longint'(start) + longint'(length);
            seq_after = (total > longint'(MAX_SEQ)) ? MAX_SEQ
                                                    : start + srb_pkg::SEQ_W'(length);
        end
    endfunction

    // held slot with the lowest start, or -1 when the table is empty
    function automatic int lowest_held();
        int best;
        begin
            best = -1;
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                if (held_valid[i] && (best < 0 || held_slot[i].seq < held_slot[best].seq))
                begin
                    best = i;
                end
            end
            lowest_held = best;
        end
    endfunction

    function automatic srb_pkg::res_item_t make_beat(
        input srb_pkg::kind_t            kind,
        input logic [srb_pkg::SEQ_W-1:0] seq,
        input logic [srb_pkg::LEN_W-1:0] length,
        input logic [srb_pkg::TAG_W-1:0] tag,
        input logic [srb_pkg::SEQ_W-1:0] ack
    );
        srb_pkg::res_item_t beat;
        begin
            beat.kind           = kind;
            beat.out_seq_number = seq;
            beat.out_length     = length;
            beat.out_tag        = tag;
            beat.ack_number     = ack;
            beat.last           = 1'b0;
            make_beat = beat;
        end
    endfunction

    // works out the beats one accepted segment causes and updates the reorder state
    task automatic predict_reorder(input srb_pkg::seg_item_t seg);
        srb_pkg::res_item_t        produced[$];
        logic [srb_pkg::SEQ_W-1:0] seq;
        logic [srb_pkg::LEN_W-1:0] length;
        logic [srb_pkg::TAG_W-1:0] tag;
        int                        low;
        int                        free_idx;
        int                        flushed;
        bit                        dup;
        begin
            seq    = seg.seq_number;
            length = seg.payload_length;
            tag    = seg.buffer_tag & srb_pkg::TAG_W'((1 << TAG_BITS) - 1);

            if (length == '0)
            begin
                // end of stream: report the expected number, state untouched
                produced.push_back(make_beat(srb_pkg::KIND_EOS, '0, '0, '0, next_seq));
            end
            else if (length > MAX_PAYLOAD)
            begin
                // oversized segment never enters the state
                produced.push_back(make_beat(srb_pkg::KIND_DISCARD, seq, length, tag, '0));
            end
            else if (seq == next_seq)
            begin
                // in order: deliver, then drain held segments in ascending start order
                produced.push_back(make_beat(srb_pkg::KIND_DELIVER, seq, length, tag, '0));
                next_seq = seq_after(seq, length);
                flushed  = 0;
                low      = lowest_held();
                while (low >= 0 && held_slot[low].seq <= next_seq)
                begin
                    if (held_slot[low].seq < next_seq)
                    begin
                        // overlapped by data already delivered
                        produced.push_back(make_beat(srb_pkg::KIND_DISCARD,
                                                     held_slot[low].seq,
                                                     held_slot[low].len,
                                                     held_slot[low].tag, '0));
                        stale_drops++;
                    end
                    else
                    begin
                        produced.push_back(make_beat(srb_pkg::KIND_DELIVER,
                                                     held_slot[low].seq,
                                                     held_slot[low].len,
                                                     held_slot[low].tag, '0));
                        next_seq = seq_after(held_slot[low].seq, held_slot[low].len);
                    end
                    held_valid[low] = 1'b0;
                    flushed++;
                    low = lowest_held();
                end
                if (flushed > deepest_flush)
                begin
                    deepest_flush = flushed;
                end
                produced.push_back(make_beat(srb_pkg::KIND_ACK, '0, '0, '0, next_seq));
            end
            else if (seq < next_seq)
            begin
                // late copy: drop it and repeat the ack
                produced.push_back(make_beat(srb_pkg::KIND_DISCARD, seq, length, tag, '0));
                produced.push_back(make_beat(srb_pkg::KIND_ACK, '0, '0, '0, next_seq));
            end
            else
            begin
                // early: hold it unless it is a duplicate or no slot is free
                free_idx = -1;
                dup      = 1'b0;
                for (int i = 0; i < WINDOW_SLOTS; i++)
                begin
                    if (held_valid[i])
                    begin
                        if (held_slot[i].seq == seq)
                        begin
                            dup = 1'b1;
                        end
                    end
                    else if (free_idx < 0)
                    begin
                        free_idx = i;
                    end
                end
                if (dup || free_idx < 0)
                begin
                    if (!dup)
                    begin
                        table_overflow++;
                    end
                    produced.push_back(make_beat(srb_pkg::KIND_DISCARD, seq, length,
                                                 tag, '0));
                end
                else
                begin
                    held_valid[free_idx]    = 1'b1;
                    held_slot[free_idx].seq = seq;
                    held_slot[free_idx].len = length;
                    held_slot[free_idx].tag = tag;
                end
            end

            // last marks the final beat caused by this segment
            foreach (produced[i])
            begin
                produced[i].last = (i == produced.size() - 1);
                due_beats.push_back(produced[i]);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // segment side
    // ------------------------------------------------------------------

    // drives one segment beat and holds it until the block takes it
    task automatic offer_segment(input srb_pkg::seg_item_t seg);
        begin
            if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                // idle burst before this beat
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            push    <= 1'b1;
            segment <= seg;
            @(posedge clk);
            while (full)
            begin
                @(posedge clk);
            end
            // accepted at this edge
            predict_reorder(seg);
            segments_sent++;
        end
    endtask

    task automatic offer_fields(
        input logic [srb_pkg::SEQ_W-1:0] seq,
        input logic [srb_pkg::LEN_W-1:0] length,
        input logic [srb_pkg::TAG_W-1:0] tag
    );
        srb_pkg::seg_item_t seg;
        begin
            seg.seq_number     = seq;
            seg.payload_length = length;
            seg.buffer_tag     = tag;
            offer_segment(seg);
        end
    endtask

    // mostly short payloads, now and then anything up to the maximum
    function automatic logic [srb_pkg::LEN_W-1:0] pick_length();
        int roll;
        begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
            begin
                pick_length = srb_pkg::LEN_W'($urandom_range(1, 64));
            end
            else if (roll < 9)
            begin
                pick_length = srb_pkg::LEN_W'($urandom_range(1, MAX_PAYLOAD));
            end
            else
            begin
                pick_length = srb_pkg::LEN_W'(MAX_PAYLOAD);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // pop stalls in bursts, counted down in pop_hold
    int pop_hold = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            pop_hold <= $urandom_range(0, 5);
            pop      <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic check_field(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        begin
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        end
    endtask

    // every beat taken is compared with the oldest one still owed
    always @(posedge clk)
    begin : check_results
        srb_pkg::res_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (due_beats.size() == 0)
            begin
                $error("result beat with none owed: kind %0d seq %0d", result.kind,
                       result.out_seq_number);
                mismatches++;
            end
            else
            begin
                want = due_beats.pop_front();
                check_field("kind", want.kind, result.kind);
                check_field("out_seq_number", want.out_seq_number, result.out_seq_number);
                check_field("out_length", want.out_length, result.out_length);
                check_field("out_tag", want.out_tag, result.out_tag);
                check_field("ack_number", want.ack_number, result.ack_number);
                check_field("last", want.last, result.last);
                beats_checked++;
                case (want.kind)
                    srb_pkg::KIND_DELIVER: deliver_beats++;
                    srb_pkg::KIND_ACK:     ack_beats++;
                    srb_pkg::KIND_EOS:     eos_beats++;
                    default:               discard_beats++;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------

    // a run of contiguous segments from the next in-order byte, mostly sent shuffled,
    // sometimes with one stretched to overlap its successor or one sent twice
    task automatic send_stream_batch();
        srb_pkg::seg_item_t        batch[$];
        srb_pkg::seg_item_t        seg;
        srb_pkg::seg_item_t        tmp;
        logic [srb_pkg::SEQ_W-1:0] at;
        int                        count;
        int                        k;
        int                        j;
        begin
            at    = next_seq;
            count = $urandom_range(1, 10);
            for (int i = 0; i < count; i++)
            begin
                seg.seq_number     = at;
                seg.payload_length = pick_length();
                seg.buffer_tag     = srb_pkg::TAG_W'($urandom);
                batch.push_back(seg);
                at = at + srb_pkg::SEQ_W'(seg.payload_length);
            end
            // overlap: the following segment turns stale or late
            if ($urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(0, count - 1);
                if (batch[k].payload_length < MAX_PAYLOAD)
                begin
                    batch[k].payload_length = srb_pkg::LEN_W'($urandom_range(
                        batch[k].payload_length + 1, MAX_PAYLOAD));
                end
            end
            // shuffle most batches, keep some in order
            if ($urandom_range(0, 3) != 0)
            begin
                for (int i = count - 1; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    tmp      = batch[i];
                    batch[i] = batch[j];
                    batch[j] = tmp;
                end
            end
            // retransmission of one segment somewhere later in the batch
            if ($urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(0, count - 1);
                batch.insert($urandom_range(k + 1, count), batch[k]);
            end
            foreach (batch[i])
            begin
                offer_segment(batch[i]);
            end
        end
    endtask

    // one stray segment: end of stream, oversized, late or a little early
    task automatic send_noise_segment();
        int roll;
        begin
            roll = $urandom_range(0, 3);
            if (roll == 0)
            begin
                offer_fields(srb_pkg::SEQ_W'($urandom), '0, srb_pkg::TAG_W'($urandom));
            end
            else if (roll == 1)
            begin
                offer_fields(srb_pkg::SEQ_W'($urandom),
                             srb_pkg::LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047)),
                             srb_pkg::TAG_W'($urandom));
            end
            else if (roll == 2 && next_seq != '0)
            begin
                offer_fields(srb_pkg::SEQ_W'($urandom_range(0, next_seq - 1)), pick_length(),
                             srb_pkg::TAG_W'($urandom));
            end
            else
            begin
                // near enough that the stream soon catches up with it
                offer_fields(next_seq + srb_pkg::SEQ_W'($urandom_range(1, 3000)),
                             pick_length(), srb_pkg::TAG_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_end_of_stream_and_oversize();
        begin
            // end of stream straight after reset reports zero
            offer_fields('0, '0, '0);
            // all-ones seq and length, far above the payload limit
            offer_fields(MAX_SEQ, {srb_pkg::LEN_W{1'b1}}, 8'hA5);
            // just over the limit, even though it starts at the expected byte
            offer_fields(next_seq, srb_pkg::LEN_W'(MAX_PAYLOAD + 1), 8'h5A);
        end
    endtask

    task automatic test_in_order_and_late();
        begin
            offer_fields(next_seq, srb_pkg::LEN_W'(1), 8'hFF);
            offer_fields(next_seq, srb_pkg::LEN_W'(MAX_PAYLOAD), 8'h00);
            // late: from the very start, and one overlapping the expected byte
            offer_fields('0, srb_pkg::LEN_W'(1), 8'h3C);
            offer_fields(next_seq - 1, srb_pkg::LEN_W'(MAX_PAYLOAD), 8'h81);
        end
    endtask

    task automatic test_early_duplicate_and_stale();
        logic [srb_pkg::SEQ_W-1:0] base;
        begin
            base = next_seq;
            offer_fields(base + 100, srb_pkg::LEN_W'(50), 8'h11);
            // duplicate start of a held segment
            offer_fields(base + 100, srb_pkg::LEN_W'(50), 8'h22);
            offer_fields(base + 300, srb_pkg::LEN_W'(20), 8'h33);
            // covers the first held segment, which then drops as stale
            offer_fields(base, srb_pkg::LEN_W'(200), 8'h44);
            // closes the gap, the held one at +300 follows it out
            offer_fields(base + 200, srb_pkg::LEN_W'(100), 8'h55);
            // end of stream with a non-zero ack and all-ones seq and tag
            offer_fields(MAX_SEQ, '0, 8'hFF);
        end
    endtask

    task automatic test_table_full_flush();
        logic [srb_pkg::SEQ_W-1:0] base;
        begin
            base = next_seq;
            // fill every slot, highest start first so slot order is not seq order
            for (int i = WINDOW_SLOTS; i >= 1; i--)
            begin
                offer_fields(base + srb_pkg::SEQ_W'(10 * i), srb_pkg::LEN_W'(10),
                             srb_pkg::TAG_W'(i));
            end
            // no room left
            offer_fields(base + srb_pkg::SEQ_W'(10 * (WINDOW_SLOTS + 1)),
                         srb_pkg::LEN_W'(10), 8'hEE);
            // releases the whole table in one go
            offer_fields(base, srb_pkg::LEN_W'(10), 8'h77);
        end
    endtask

    task automatic test_reordered_streams(input int item_count);
        int stop_at;
        begin
            stop_at = segments_sent + item_count;
            while (segments_sent < stop_at)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    send_stream_batch();
                end
                else
                begin
                    send_noise_segment();
                end
            end
        end
    endtask

    task automatic test_drain_pause();
        begin
            send_stream_batch();
            // hold off until every owed beat has come out
            push <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (due_beats.size() != 0);
            send_stream_batch();
        end
    endtask

    task automatic test_back_to_back(input int item_count);
        begin
            idle_enable = 1'b0;
            test_reordered_streams(item_count);
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        foreach (held_valid[i])
        begin
            held_valid[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_end_of_stream_and_oversize();
        test_in_order_and_late();
        test_early_duplicate_and_stale();
        test_table_full_flush();
        test_reordered_streams(200);
        test_drain_pause();
        test_reordered_streams(40);
        test_back_to_back(60);

        push <= 1'b0;
        while (due_beats.size() != 0)
        begin
            @(posedge clk);
        end
        // anything the block still emits now has no owner
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d segments and %0d result beats: %0d delivered, %0d acks, %0d discarded, %0d end of stream",
                 segments_sent, beats_checked, deliver_beats, ack_beats, discard_beats, eos_beats);
        $display("table overflowed %0d times, %0d stale entries dropped, deepest flush %0d segments",
                 table_overflow, stale_drops, deepest_flush);
        if (mismatches == 0)
        begin
            $display("tb_segment_reorder_buffer OK");
        end
        else
        begin
            $display("tb_segment_reorder_buffer NOT OK");
        end
        $finish;
    end

    // cycle counter: a hung handshake ends the run here
    int cycle_count = 0;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_segment_reorder_buffer NOT OK");
        $finish;
    end

endmodule

### sim.f
hdl/srb_pkg.sv
hdl/srb_fifo.sv
hdl/srb_front.sv
hdl/srb_back.sv
hdl/segment_reorder_buffer.sv
verif/tb_segment_reorder_buffer.sv
